### hdl/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg: shared types and constants for the k-mer counter
// Sizes, payload structs, the operation code and the back-end states.
// ----------------------------------------------------------------------------
package kcl_pkg;

    localparam int MAX_KMER    = 8;
    localparam int COUNT_BITS  = 32;
    localparam int CODE_W      = 2 * MAX_KMER;
    localparam int FILL_W      = $clog2(MAX_KMER + 1);
    localparam int LEN_W       = (FILL_W > 4) ? FILL_W : 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic FUNC_COUNT = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic       func;
        logic [1:0] base;
        logic       seq_start;
    } in_item_t;

    typedef struct packed {
        logic [15:0] kmer_code;
        logic [31:0] kmer_count;
    } out_item_t;

    typedef struct packed {
        logic              func;
        logic [CODE_W-1:0] code;
    } op_t;

    typedef struct packed {
        logic clearing;
        logic idle;
    } back_status_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_WRITE
    } back_state_t;

endpackage

### hdl/kcl_front.sv
// ----------------------------------------------------------------------------
// kcl_front: window tracking and classification
// Shifts each accepted base into the window and queues an operation for
// every transfer that completes a k-mer.
// ----------------------------------------------------------------------------
module kcl_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  kcl_pkg::in_item_t            item,
    input  logic [3:0]                   kmer_len,
    output logic                         push,
    output kcl_pkg::op_t                 push_op
);

    logic [kcl_pkg::CODE_W-1:0] window_reg, window_next;
    logic [kcl_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic [kcl_pkg::CODE_W-1:0] window_base;
    logic [kcl_pkg::FILL_W-1:0] fill_base;
    logic [kcl_pkg::LEN_W-1:0]  len_ext;
    logic [kcl_pkg::LEN_W-1:0]  eff_len;
    logic [kcl_pkg::CODE_W-1:0] code_mask;
    logic                       complete;

    always_comb
    begin
        window_base = item.seq_start ? '0 : window_reg;
        fill_base   = item.seq_start ? '0 : fill_reg;
        window_next = (window_base << 2) | kcl_pkg::CODE_W'(item.base);
        if (fill_base < kcl_pkg::FILL_W'(kcl_pkg::MAX_KMER))
        begin
            fill_next = fill_base + kcl_pkg::FILL_W'(1);
        end
        else
        begin
            fill_next = fill_base;
        end
        len_ext = kcl_pkg::LEN_W'(kmer_len);
        if (len_ext == '0)
        begin
            eff_len = kcl_pkg::LEN_W'(1);
        end
        else if (len_ext > kcl_pkg::LEN_W'(kcl_pkg::MAX_KMER))
        begin
            eff_len = kcl_pkg::LEN_W'(kcl_pkg::MAX_KMER);
        end
        else
        begin
            eff_len = len_ext;
        end
        code_mask = ~({kcl_pkg::CODE_W{1'b1}} << {eff_len, 1'b0});
        complete  = kcl_pkg::LEN_W'(fill_next) >= eff_len;
    end

    assign push         = accept && complete;
    assign push_op.func = item.func;
    assign push_op.code = window_next & code_mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            fill_reg   <= '0;
        end
        else if (accept)
        begin
            window_reg <= window_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

### hdl/kcl_queue.sv
// ----------------------------------------------------------------------------
// kcl_queue: operation queue
// A short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module kcl_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  kcl_pkg::op_t push_op,
    input  logic         pop,
    output kcl_pkg::op_t pop_op,
    output logic         full,
    output logic         empty
);

    kcl_pkg::op_t                entry_reg [kcl_pkg::QUEUE_DEPTH];
    logic [kcl_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [kcl_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [kcl_pkg::QPTR_W:0]    count_reg, count_next;
    logic                        do_push, do_pop;

    assign full    = count_reg == (kcl_pkg::QPTR_W + 1)'(kcl_pkg::QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_op  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + kcl_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + kcl_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (kcl_pkg::QPTR_W + 1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (kcl_pkg::QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

### hdl/kcl_back.sv
// ----------------------------------------------------------------------------
// kcl_back: count table engine
// Clears the table after reset, then performs one read-modify-write or
// lookup per queued operation and issues the result.
// ----------------------------------------------------------------------------
module kcl_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  kcl_pkg::op_t          q_op,
    output logic                  q_pop,
    output kcl_pkg::back_status_t status,
    output logic                  done,
    output kcl_pkg::out_item_t    result
);

    localparam int DEPTH = 1 << kcl_pkg::CODE_W;
    localparam logic [kcl_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [kcl_pkg::COUNT_BITS-1:0] mem [DEPTH];
    logic [kcl_pkg::COUNT_BITS-1:0] rd_data_reg;

    kcl_pkg::back_state_t        state_reg, state_next;
    logic [kcl_pkg::CODE_W-1:0]  clr_addr_reg, clr_addr_next;
    kcl_pkg::op_t                op_reg;
    logic                        done_reg, done_next;
    kcl_pkg::out_item_t          result_reg;

    logic                           mem_we;
    logic [kcl_pkg::CODE_W-1:0]     mem_waddr;
    logic [kcl_pkg::COUNT_BITS-1:0] mem_wdata;
    logic                           res_load;
    logic [kcl_pkg::COUNT_BITS-1:0] cnt_inc, cnt_new;
    logic [63:0]                    cnt_wide;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kcl_pkg::B_CLEAR:
            begin
                if (clr_addr_reg == '1)
                begin
                    state_next = kcl_pkg::B_IDLE;
                end
            end
            kcl_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = kcl_pkg::B_READ;
                end
            end
            kcl_pkg::B_READ:  state_next = kcl_pkg::B_WRITE;
            kcl_pkg::B_WRITE: state_next = kcl_pkg::B_IDLE;
            default:          state_next = kcl_pkg::B_CLEAR;
        endcase
    end

    always_comb
    begin
        cnt_inc  = (rd_data_reg != COUNT_MAX) ?
                   rd_data_reg + kcl_pkg::COUNT_BITS'(1) : rd_data_reg;
        cnt_new  = (op_reg.func == kcl_pkg::FUNC_COUNT) ? cnt_inc : rd_data_reg;
        cnt_wide = 64'(cnt_new);
    end

    always_comb
    begin
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = op_reg.code;
        mem_wdata     = cnt_new;
        res_load      = 1'b0;
        clr_addr_next = clr_addr_reg;
        case (state_reg)
            kcl_pkg::B_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + kcl_pkg::CODE_W'(1);
            end
            kcl_pkg::B_IDLE:
            begin
                q_pop = !q_empty;
            end
            kcl_pkg::B_READ:
            begin
            end
            kcl_pkg::B_WRITE:
            begin
                mem_we   = op_reg.func == kcl_pkg::FUNC_COUNT;
                res_load = 1'b1;
            end
            default:
            begin
            end
        endcase
        done_next = res_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= kcl_pkg::B_CLEAR;
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg <= q_op;
        end
        if (res_load)
        begin
            result_reg.kmer_code  <= 16'(op_reg.code);
            result_reg.kmer_count <= (cnt_wide > 64'hFFFF_FFFF) ?
                                     32'hFFFF_FFFF : cnt_wide[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[op_reg.code];
    end

    assign status.clearing = state_reg == kcl_pkg::B_CLEAR;
    assign status.idle     = state_reg == kcl_pkg::B_IDLE;
    assign done            = done_reg;
    assign result          = result_reg;

endmodule

### hdl/kmer_count_and_lookup.sv
// ----------------------------------------------------------------------------
// kmer_count_and_lookup: k-mer counter and lookup
// A base that completes a window is queued; the back end pops it, reads the
// table, updates it for a count op, registers the result, one window at a time.
// Other bases are taken every cycle while the four-entry queue has room.
// After reset, busy stays high while all 65536 table entries are cleared.
// Results cannot be stalled; each is strobed for exactly one cycle.
// ----------------------------------------------------------------------------
module kmer_count_and_lookup (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  kcl_pkg::in_item_t  item,
    output logic               done,
    output kcl_pkg::out_item_t result,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_wdata
);

    logic [3:0]            kmer_len_reg;
    logic                  accept;
    logic                  push;
    kcl_pkg::op_t          push_op;
    logic                  q_pop;
    kcl_pkg::op_t          q_op;
    logic                  q_full;
    logic                  q_empty;
    kcl_pkg::back_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_len_reg <= 4'd8;
        end
        else if (cfg_we)
        begin
            kmer_len_reg <= cfg_wdata;
        end
    end

    assign busy   = status.clearing || q_full;
    assign accept = start && !busy;

    kcl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .kmer_len (kmer_len_reg),
        .push     (push),
        .push_op  (push_op)
    );

    kcl_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (q_pop),
        .pop_op  (q_op),
        .full    (q_full),
        .empty   (q_empty)
    );

    kcl_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_op    (q_op),
        .q_pop   (q_pop),
        .status  (status),
        .done    (done),
        .result  (result)
    );

    // A transfer that completes a window must always find room in the queue.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_full)
        else $error("operation queue overflow");

    // Results are spaced by the table access loop, never on adjacent cycles.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe held for more than one cycle");

    // No transfer is taken while the table is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n) status.clearing |-> !accept)
        else $error("transfer accepted during table clear");

    // The back end only leaves idle when an operation was waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (status.idle && q_empty) |=> !done)
        else $error("result issued without a queued operation");

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for kmer_count_and_lookup
// Streams 2-bit bases through the command port and keeps its own copy of
// the window, the fill level, the k-mer length and the count table. Each
// result transfer is compared with the oldest predicted result. A short
// directed part covers the length limits and mid-stream changes, and random
// sequences follow under several k-mer lengths.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TABLE_DEPTH  = 1 << kcl_pkg::CODE_W;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    kcl_pkg::in_item_t  item;
    logic               done;
    kcl_pkg::out_item_t result;
    logic               cfg_we;
    logic [3:0]         cfg_wdata;

    logic [3:0]                   len_reg;
    logic [kcl_pkg::CODE_W-1:0]   win_bits;
    int unsigned                  win_fill;
    bit [kcl_pkg::COUNT_BITS-1:0] tally [0:TABLE_DEPTH-1];
    kcl_pkg::out_item_t           pending_kmers [$];
    int                           errors;
    int unsigned                  cycle_cnt;
    bit                           idle_en;

    kmer_count_and_lookup dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Applies one accepted base to the window and, when the window is
    // complete, to the table, queuing the result that it must produce.
    function automatic void predict_base(input kcl_pkg::in_item_t it);
        int unsigned                  k;
        logic [kcl_pkg::CODE_W-1:0]   mask;
        logic [kcl_pkg::CODE_W-1:0]   code;
        bit [kcl_pkg::COUNT_BITS-1:0] cnt;
        kcl_pkg::out_item_t           want;
        k = 32'(len_reg);
        if (k < 1)
            k = 1;
        if (k > kcl_pkg::MAX_KMER)
            k = kcl_pkg::MAX_KMER;
        if (it.seq_start)
        begin
            win_bits = '0;
            win_fill = 0;
        end
        win_bits = {win_bits[kcl_pkg::CODE_W-3:0], it.base};
        if (win_fill < kcl_pkg::MAX_KMER)
            win_fill++;
        if (win_fill >= k)
        begin
            mask = {kcl_pkg::CODE_W{1'b1}} >> (kcl_pkg::CODE_W - 2 * k);
            code = win_bits & mask;
            cnt = tally[code];
            if (it.func == kcl_pkg::FUNC_COUNT)
            begin
                if (cnt != '1)
                    cnt = cnt + 1'b1;
                tally[code] = cnt;
            end
            want.kmer_code  = 16'(code);
            want.kmer_count = 32'(cnt);
            pending_kmers = {pending_kmers, want};
        end
    endfunction

    always @(posedge clk)
    begin
        kcl_pkg::out_item_t want;
        if (rst_n && done)
        begin
            if (pending_kmers.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected, actual code %h count %0d",
                         $time, result.kmer_code, result.kmer_count);
            end
            else
            begin
                want = pending_kmers.pop_front();
                if (result.kmer_code !== want.kmer_code)
                begin
                    errors++;
                    $display("%0t: kmer_code expected %h actual %h",
                             $time, want.kmer_code, result.kmer_code);
                end
                if (result.kmer_count !== want.kmer_count)
                begin
                    errors++;
                    $display("%0t: kmer_count expected %0d actual %0d",
                             $time, want.kmer_count, result.kmer_count);
                end
            end
        end
    end

    task automatic send_base(input logic fn, input logic [1:0] b, input logic first);
        kcl_pkg::in_item_t it;
        it.func      = fn;
        it.base      = b;
        it.seq_start = first;
        @(negedge clk);
        if (idle_en && $urandom_range(0, 99) < 10)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        item  = it;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        predict_base(it);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start = 1'b0;
        while (pending_kmers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_kmer_len(input logic [3:0] v);
        wait_idle();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        len_reg   = v;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Reset length of eight: seven bases give nothing, then all-T windows.
    task automatic test_default_length();
        int i;
        for (i = 0; i < 8; i++)
            send_base(kcl_pkg::FUNC_COUNT, 2'd3, i == 0);
        send_base(kcl_pkg::FUNC_QUERY, 2'd3, 1'b0);
    endtask

    // A length of zero acts as one and a length above the maximum acts as
    // the maximum; the window is kept across the change to the maximum.
    task automatic test_length_bounds();
        write_kmer_len(4'd0);
        send_base(kcl_pkg::FUNC_COUNT, 2'd0, 1'b1);
        send_base(kcl_pkg::FUNC_QUERY, 2'd1, 1'b0);
        send_base(kcl_pkg::FUNC_COUNT, 2'd2, 1'b0);
        send_base(kcl_pkg::FUNC_COUNT, 2'd3, 1'b0);
        write_kmer_len(4'd15);
        send_base(kcl_pkg::FUNC_COUNT, 2'd0, 1'b0);
        send_base(kcl_pkg::FUNC_QUERY, 2'd1, 1'b0);
        send_base(kcl_pkg::FUNC_COUNT, 2'd2, 1'b0);
        send_base(kcl_pkg::FUNC_QUERY, 2'd3, 1'b0);
    endtask

    // Shortening the length mid-stream completes the window at once.
    task automatic test_midstream_length();
        write_kmer_len(4'd8);
        send_base(kcl_pkg::FUNC_COUNT, 2'd2, 1'b1);
        send_base(kcl_pkg::FUNC_COUNT, 2'd1, 1'b0);
        write_kmer_len(4'd2);
        send_base(kcl_pkg::FUNC_COUNT, 2'd3, 1'b0);
    endtask

    // A new sequence empties the window even when it was complete.
    task automatic test_sequence_restart();
        send_base(kcl_pkg::FUNC_COUNT, 2'd1, 1'b0);
        send_base(kcl_pkg::FUNC_COUNT, 2'd2, 1'b1);
        send_base(kcl_pkg::FUNC_QUERY, 2'd1, 1'b0);
    endtask

    task automatic test_random_sequences(input int n_items, input int unsigned query_pct);
        int         sent;
        int         seg_len;
        int         i;
        bit         narrow;
        logic [1:0] b;
        logic       fn;
        logic       first;
        sent = 0;
        while (sent < n_items)
        begin
            seg_len = $urandom_range(1, 40);
            narrow  = ($urandom_range(0, 3) == 0);
            for (i = 0; i < seg_len && sent < n_items; i++)
            begin
                b  = narrow ? 2'($urandom_range(0, 1)) : 2'($urandom_range(0, 3));
                fn = ($urandom_range(0, 99) < query_pct) ?
                     kcl_pkg::FUNC_QUERY : kcl_pkg::FUNC_COUNT;
                if (i == 0)
                    first = ($urandom_range(0, 9) != 0);
                else
                    first = ($urandom_range(0, 99) < 2);
                send_base(fn, b, first);
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [3:0] lens [10];
        int         p;
        lens = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd4, 4'd6, 4'd3, 4'd5, 4'd7};
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        len_reg   = 4'd8;
        win_bits  = '0;
        win_fill  = 0;
        errors    = 0;
        cycle_cnt = 0;
        idle_en   = 1'b1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (busy)
            @(posedge clk);

        test_default_length();
        test_length_bounds();
        test_midstream_length();
        test_sequence_restart();
        for (p = 0; p < 10; p++)
        begin
            write_kmer_len(lens[p]);
            idle_en = (p != 3);
            test_random_sequences(140, (p % 2 == 0) ? 30 : 60);
        end

        wait_idle();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
hdl/kcl_pkg.sv
hdl/kcl_front.sv
hdl/kcl_queue.sv
hdl/kcl_back.sv
hdl/kmer_count_and_lookup.sv
dv/testbench.sv
